// ----- rtl/core/mkrs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mkrs_pkg: shared types and constants of the multi-key record sorter
// Field widths, the default store size and the records that travel along
// the row of sorting cells.
// ----------------------------------------------------------------------------
package mkrs_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int ID_W  = 32;
    localparam int AGE_W = 7;
    localparam int SAL_W = 32;
    // sort key: salary, age, male bit
    localparam int KEY_W = SAL_W + AGE_W + 1;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_rec;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } t_cell_cmd;

endpackage
`default_nettype wire

// ----- rtl/core/mkrs_channels.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mkrs channels: record input and sorted result output
// Valid/ready channels; a word moves at an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface mkrs_rec_if;
    logic                       valid;
    logic                       ready;
    logic [mkrs_pkg::ID_W-1:0]  staff_id;
    logic [mkrs_pkg::AGE_W-1:0] age;
    logic                       is_female;
    logic [mkrs_pkg::SAL_W-1:0] salary;
    logic                       last_record;

    modport source (
        output valid, staff_id, age, is_female, salary, last_record,
        input  ready
    );
    modport sink (
        input  valid, staff_id, age, is_female, salary, last_record,
        output ready
    );
endinterface

interface mkrs_res_if;
    logic                       valid;
    logic                       ready;
    logic [mkrs_pkg::SAL_W-1:0] out_salary;
    logic [mkrs_pkg::ID_W-1:0]  out_staff_id;
    logic                       group_start;
    logic                       overflow;
    logic                       last_result;

    modport source (
        output valid, out_salary, out_staff_id, group_start, overflow, last_result,
        input  ready
    );
    modport sink (
        input  valid, out_salary, out_staff_id, group_start, overflow, last_result,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/core/mkrs_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mkrs_cell: one slot of the insertion sorting row
// Holds one record; on insert it keeps, takes the new record or takes its
// left neighbor; on shift out it takes its right neighbor.
// ----------------------------------------------------------------------------
module mkrs_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mkrs_pkg::t_cell_cmd i_cmd,
    input  mkrs_pkg::t_rec      i_new,
    input  mkrs_pkg::t_rec      i_left,
    input  logic                i_left_before,
    input  mkrs_pkg::t_rec      i_right,
    output mkrs_pkg::t_rec      o_rec,
    output logic                o_before
);

    logic                       r_valid;
    logic [mkrs_pkg::KEY_W-1:0] r_key;
    logic [mkrs_pkg::ID_W-1:0]  r_id;
    mkrs_pkg::t_rec             n_rec;

    assign o_rec.valid = r_valid;
    assign o_rec.key   = r_key;
    assign o_rec.id    = r_id;

    // empty slot counts as larger than any record
    assign o_before = !r_valid || ({i_new.key, i_new.id} < {r_key, r_id});

    always_comb begin
        n_rec = o_rec;
        if (i_cmd.insert && o_before) begin
            n_rec = i_left_before ? i_left : i_new;
        end else if (i_cmd.shift_out) begin
            n_rec = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_rec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_rec.key;
        r_id  <= n_rec.id;
    end

endmodule
`default_nettype wire

// ----- rtl/core/multi_key_record_sorter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_key_record_sorter: sorts employee records by salary, age, sex, id
// Records load into a row of insertion cells and stream out sorted.
// ----------------------------------------------------------------------------
// Records are taken one per cycle while loading: each word is placed in
// its sorted slot in the same cycle by a row of CAPACITY cells that compare
// it against their contents in parallel. The word marked last_record starts
// a run: from the next cycle the row shifts toward cell 0 and one result
// leaves per cycle while the sink is ready; no new record is taken until
// the run has drained. Words beyond CAPACITY are dropped and flag overflow
// on every result of the run.
module multi_key_record_sorter #(
    parameter int CAPACITY = mkrs_pkg::CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mkrs_rec_if.sink   i_rec,
    mkrs_res_if.source o_res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_LOAD,
        S_DRAIN
    } t_state;

    t_state                     r_state;
    logic [CNT_W-1:0]           r_count;
    logic                       r_dropped;
    logic                       r_first;
    logic [mkrs_pkg::SAL_W-1:0] r_prev_sal;

    logic                       r_out_valid;
    logic [mkrs_pkg::SAL_W-1:0] r_out_salary;
    logic [mkrs_pkg::ID_W-1:0]  r_out_id;
    logic                       r_out_start;
    logic                       r_out_ovf;
    logic                       r_out_last;

    mkrs_pkg::t_rec             w_new;
    mkrs_pkg::t_rec             w_rec    [CAPACITY];
    logic                       w_before [CAPACITY];
    logic [CAPACITY-1:0]        w_valid;
    mkrs_pkg::t_cell_cmd        w_cmd;

    logic                       w_accept;
    logic                       w_full;
    logic                       w_pop;
    logic [mkrs_pkg::SAL_W-1:0] w_head_sal;

    assign i_rec.ready = (r_state == S_LOAD);
    assign w_accept    = i_rec.valid && i_rec.ready;
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_pop       = (r_state == S_DRAIN) && (!r_out_valid || o_res.ready);
    assign w_head_sal  = w_rec[0].key[mkrs_pkg::KEY_W-1 -: mkrs_pkg::SAL_W];

    assign w_new.valid = 1'b1;
    assign w_new.key   = {i_rec.salary, i_rec.age, !i_rec.is_female};
    assign w_new.id    = i_rec.staff_id;

    assign w_cmd.insert    = w_accept && !w_full;
    assign w_cmd.shift_out = w_pop;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            mkrs_pkg::t_rec w_left;
            mkrs_pkg::t_rec w_right;
            logic           w_left_before;

            if (g == 0) begin : g_head
                assign w_left        = '0;
                assign w_left_before = 1'b0;
            end else begin : g_mid
                assign w_left        = w_rec[g-1];
                assign w_left_before = w_before[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_body
                assign w_right = w_rec[g+1];
            end

            mkrs_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_cmd         (w_cmd),
                .i_new         (w_new),
                .i_left        (w_left),
                .i_left_before (w_left_before),
                .i_right       (w_right),
                .o_rec         (w_rec[g]),
                .o_before      (w_before[g])
            );

            assign w_valid[g] = w_rec[g].valid;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_full) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (i_rec.last_record) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (w_pop) begin
                        r_out_salary <= w_head_sal;
                        r_out_id     <= w_rec[0].id;
                        r_out_start  <= r_first || (w_head_sal != r_prev_sal);
                        r_out_ovf    <= r_dropped;
                        r_out_last   <= (r_count == CNT_W'(1));
                        r_prev_sal   <= w_head_sal;
                        // next word opens a new run after the final one
                        r_first      <= (r_count == CNT_W'(1));
                        r_count      <= r_count - CNT_W'(1);
                        if (r_count == CNT_W'(1)) begin
                            r_state   <= S_LOAD;
                            r_dropped <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.out_salary   = r_out_salary;
    assign o_res.out_staff_id = r_out_id;
    assign o_res.group_start  = r_out_start;
    assign o_res.overflow     = r_out_ovf;
    assign o_res.last_result  = r_out_last;

    // occupied cells form a prefix; this checks that their number equals the count
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("cell occupancy differs from record count");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= CAPACITY)
        else $error("record count above capacity");

    a_drain_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> w_rec[0].valid)
        else $error("draining with empty head cell");

    a_sorted_salary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !r_first) |-> (w_head_sal >= r_prev_sal))
        else $error("salary order broken on output");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && r_count == CNT_W'(1)) |=> (r_state == S_LOAD && r_count == '0 && !r_dropped))
        else $error("run did not return to loading");

endmodule
`default_nettype wire
